FILE: design/tkls_pkg.sv
// ----------------------------------------------------------------------------
// tkls_pkg
// Shared constants and command/status types for the lowest-cost selector.
// ----------------------------------------------------------------------------
package tkls_pkg;

    localparam int KEEP_MAX  = 8;
    localparam int COST_BITS = 32;
    localparam int ID_BITS   = 8;

    localparam int SLOTS = 8;
    localparam int LIM   = (KEEP_MAX < 1) ? 1 : ((KEEP_MAX > SLOTS) ? SLOTS : KEEP_MAX);
    localparam int CNT_W = $clog2(LIM + 1);
    localparam int IDX_W = (LIM > 1) ? $clog2(LIM) : 1;

    localparam int ID_W   = 8;
    localparam int COST_W = 32;
    localparam int RANK_W = 3;

    localparam logic [ID_W-1:0] ID_MASK =
        (ID_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((64'd1 << ID_BITS) - 64'd1);
    localparam logic [COST_W-1:0] COST_MASK =
        (COST_BITS >= COST_W) ? {COST_W{1'b1}} : COST_W'((64'd1 << COST_BITS) - 64'd1);

    typedef struct packed {
        logic insert;
        logic emit;
    } tkls_cmd_t;

    typedef struct packed {
        logic out_free;
        logic emit_last;
    } tkls_status_t;

endpackage

FILE: design/tkls_dp.sv
// ----------------------------------------------------------------------------
// tkls_dp
// Datapath: sorted and arrival-order lists, counters and the output register.
// ----------------------------------------------------------------------------
module tkls_dp
    import tkls_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  tkls_cmd_t           cmd,
    output tkls_status_t        status,
    input  logic [ID_W-1:0]     cand_id,
    input  logic [COST_W-1:0]   cost,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ID_W-1:0]     chosen_id,
    output logic [RANK_W-1:0]   rank,
    output logic                empty_set,
    output logic                last_result
);

    logic [ID_W-1:0]   sid_reg  [LIM];
    logic [ID_W-1:0]   sid_next [LIM];
    logic [COST_W-1:0] scost_reg  [LIM];
    logic [COST_W-1:0] scost_next [LIM];
    logic [ID_W-1:0]   aid_reg  [LIM];
    logic [ID_W-1:0]   aid_next [LIM];

    logic [CNT_W-1:0] ucount_reg, ucount_next;
    logic [CNT_W-1:0] kcount_reg, kcount_next;
    logic [IDX_W-1:0] eidx_reg, eidx_next;

    logic              out_valid_reg, out_valid_next;
    logic [ID_W-1:0]   chosen_id_reg, chosen_id_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic              empty_reg, empty_next;
    logic              last_reg, last_next;

    logic [ID_W-1:0]   new_id;
    logic [COST_W-1:0] new_cost;
    logic [CNT_W-1:0]  pos;
    logic              is_empty;
    logic              is_sorted;
    logic [CNT_W-1:0]  emit_n;
    logic              emit_last;

    assign new_id    = cand_id & ID_MASK;
    assign new_cost  = cost & COST_MASK;
    assign is_empty  = (ucount_reg == '0);
    assign is_sorted = (ucount_reg >= CNT_W'(LIM));
    assign emit_n    = is_sorted ? kcount_reg : ucount_reg;
    assign emit_last = is_empty || ((CNT_W'(eidx_reg) + CNT_W'(1)) == emit_n);

    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.emit_last = emit_last;

    always_comb
    begin
        pos = kcount_reg;
        for (int i = LIM - 1; i >= 0; i--)
        begin
            if ((CNT_W'(i) < kcount_reg) && (scost_reg[i] > new_cost))
            begin
                pos = CNT_W'(i);
            end
        end
    end

    always_comb
    begin
        sid_next       = sid_reg;
        scost_next     = scost_reg;
        aid_next       = aid_reg;
        ucount_next    = ucount_reg;
        kcount_next    = kcount_reg;
        eidx_next      = eidx_reg;
        out_valid_next = out_valid_reg;
        chosen_id_next = chosen_id_reg;
        rank_next      = rank_reg;
        empty_next     = empty_reg;
        last_next      = last_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.insert)
        begin
            for (int i = 0; i < LIM; i++)
            begin
                if ((ucount_reg < CNT_W'(LIM)) && (ucount_reg == CNT_W'(i)))
                begin
                    aid_next[i] = new_id;
                end
                if (CNT_W'(i) == pos)
                begin
                    sid_next[i]   = new_id;
                    scost_next[i] = new_cost;
                end
                else if ((i > 0) && (CNT_W'(i) > pos))
                begin
                    sid_next[i]   = sid_reg[(i > 0) ? i - 1 : 0];
                    scost_next[i] = scost_reg[(i > 0) ? i - 1 : 0];
                end
            end
            if (ucount_reg < CNT_W'(LIM))
            begin
                ucount_next = ucount_reg + CNT_W'(1);
            end
            if (kcount_reg < CNT_W'(LIM))
            begin
                kcount_next = kcount_reg + CNT_W'(1);
            end
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            empty_next     = is_empty;
            last_next      = emit_last;
            rank_next      = RANK_W'(eidx_reg);
            if (is_empty)
            begin
                chosen_id_next = '0;
            end
            else if (is_sorted)
            begin
                chosen_id_next = sid_reg[0];
            end
            else
            begin
                chosen_id_next = aid_reg[0];
            end
            for (int i = 0; i < LIM - 1; i++)
            begin
                sid_next[i] = sid_reg[i + 1];
                aid_next[i] = aid_reg[i + 1];
            end
            if (emit_last)
            begin
                ucount_next = '0;
                kcount_next = '0;
                eidx_next   = '0;
            end
            else
            begin
                eidx_next = eidx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ucount_reg    <= '0;
            kcount_reg    <= '0;
            eidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ucount_reg    <= ucount_next;
            kcount_reg    <= kcount_next;
            eidx_reg      <= eidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sid_reg       <= sid_next;
        scost_reg     <= scost_next;
        aid_reg       <= aid_next;
        chosen_id_reg <= chosen_id_next;
        rank_reg      <= rank_next;
        empty_reg     <= empty_next;
        last_reg      <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign chosen_id   = chosen_id_reg;
    assign rank        = rank_reg;
    assign empty_set   = empty_reg;
    assign last_result = last_reg;

endmodule

FILE: design/tkls_ctrl.sv
// ----------------------------------------------------------------------------
// tkls_ctrl
// Controller: takes in requests until the final one, then drives emission.
// ----------------------------------------------------------------------------
module tkls_ctrl
    import tkls_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         usable,
    input  logic         final_item,
    input  tkls_status_t status,
    output tkls_cmd_t    cmd
);

    typedef enum logic {
        ST_TAKE,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_TAKE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd.insert = 1'b0;
        cmd.emit   = 1'b0;
        case (state_reg)
            ST_TAKE:
            begin
                cmd.insert = accept && usable;
                if (accept && final_item)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = status.out_free;
                if (status.out_free && status.emit_last)
                begin
                    state_next = ST_TAKE;
                end
            end
            default:
            begin
                state_next = ST_TAKE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_TAKE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/top_k_lowest_cost_select_top.sv
// Throughput: one candidate request per cycle while a set is being collected.
// After the final request the controller enters its emit state; the first result is then registered at the output.
// Emission: one result per cycle while the output is free, one to eight per set; input waits meanwhile.
// The input rate rests on the sorted insert, which is done over all slots in parallel.
// Reset clears both counts, the emit index and the output valid; list contents stay unset.
// ----------------------------------------------------------------------------
// top_k_lowest_cost_select_top
// Keeps up to eight usable candidates; emits the cheapest eight in cost order, or fewer in arrival order.
// ----------------------------------------------------------------------------
module top_k_lowest_cost_select_top
    import tkls_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ID_W-1:0]     cand_id,
    input  logic                usable,
    input  logic [COST_W-1:0]   cost,
    input  logic                final_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ID_W-1:0]     chosen_id,
    output logic [RANK_W-1:0]   rank,
    output logic                empty_set,
    output logic                last_result
);

    tkls_cmd_t    cmd;
    tkls_status_t status;

    tkls_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .usable     (usable),
        .final_item (final_item),
        .status     (status),
        .cmd        (cmd)
    );

    tkls_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cand_id     (cand_id),
        .cost        (cost),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .chosen_id   (chosen_id),
        .rank        (rank),
        .empty_set   (empty_set),
        .last_result (last_result)
    );

endmodule
